// ===== sv/vtpy_pkg.sv =====
// vtpy_pkg: shared types, constants and angle table for the vector to pitch/yaw core
// no dependencies

package vtpy_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned XW = 34;       // datapath width for micro-rotations
  localparam int unsigned AW = 28;       // accumulator width, 2^-16 degree
  localparam int unsigned IdxW = $clog2(CordicSteps + 1);

  typedef logic signed [XW-1:0] dat_t;
  typedef logic signed [AW-1:0] acc_t;

  // one micro-rotation stage payload
  typedef struct packed {
    logic valid;
    logic zero;
    dat_t x;
    dat_t y;
    acc_t acc;
    dat_t z;
    logic signed [14:0] yaw;
  } stage_t;

  // atan(2^-i) in degrees, scaled by 2^16
  function automatic acc_t atan_lut(input logic [4:0] idx);
    acc_t r;
    unique case (idx)
      5'd0:  r = AW'(2949120);
      5'd1:  r = AW'(1740967);
      5'd2:  r = AW'(919879);
      5'd3:  r = AW'(466945);
      5'd4:  r = AW'(234379);
      5'd5:  r = AW'(117266);
      5'd6:  r = AW'(58666);
      5'd7:  r = AW'(29335);
      5'd8:  r = AW'(14668);
      5'd9:  r = AW'(7334);
      5'd10: r = AW'(3667);
      5'd11: r = AW'(1833);
      5'd12: r = AW'(917);
      5'd13: r = AW'(458);
      5'd14: r = AW'(229);
      5'd15: r = AW'(115);
      5'd16: r = AW'(57);
      5'd17: r = AW'(29);
      5'd18: r = AW'(14);
      5'd19: r = AW'(7);
      5'd20: r = AW'(4);
      5'd21: r = AW'(2);
      5'd22: r = AW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/vtpy_rot.sv =====
// vtpy_rot: one registered CORDIC vectoring micro-rotation stage
// depends on vtpy_pkg

module vtpy_rot (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [4:0]       shift_i,
  input  vtpy_pkg::stage_t in_i,
  output vtpy_pkg::stage_t out_o
);
  import vtpy_pkg::*;

  stage_t st_d, st_q;
  dat_t   xs, ys;

  // rotate toward y = 0 using the old x and y
  always_comb begin
    xs = in_i.x >>> shift_i;
    ys = in_i.y >>> shift_i;
    st_d = in_i;
    if (in_i.y > 0) begin
      st_d.x   = in_i.x + ys;
      st_d.y   = in_i.y - xs;
      st_d.acc = in_i.acc + atan_lut(shift_i);
    end else begin
      st_d.x   = in_i.x - ys;
      st_d.y   = in_i.y + xs;
      st_d.acc = in_i.acc - atan_lut(shift_i);
    end
  end

  // valid and payload both reset to zero, then follow the rotated values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign out_o = st_q;

endmodule

// ===== sv/vector_to_pitch_yaw_core.sv =====
// vector_to_pitch_yaw_core: pipelined two-pass CORDIC, vector to pitch and yaw
// depends on vtpy_pkg and vtpy_rot
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+---------------------------
//  command  | dir_x_i, dir_y_i, dir_z_i      | start_i while busy_o low
//  result   | pitch_angle_o, yaw_angle_o     | done_o, one cycle, no stall
//
// one vector enters every cycle; busy_o is always low
// the pipeline has 2*CordicSteps + 4 register stages: prep, yaw rotations, yaw round and
// gain multiply, gain shift, pitch rotations, pitch round
// done_o is registered from the valid bit at the end of the pitch pass
// reset clears valid bits and payloads of the pipeline stages, not the product or output angles

module vector_to_pitch_yaw_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic signed [15:0]  dir_x_i,
  input  logic signed [15:0]  dir_y_i,
  input  logic signed [15:0]  dir_z_i,
  output logic                done_o,
  output logic signed [13:0]  pitch_angle_o,
  output logic signed [14:0]  yaw_angle_o
);
  import vtpy_pkg::*;

  localparam int unsigned NS = CordicSteps;

  stage_t a_pipe [NS+1];
  stage_t b_pipe [NS+1];
  stage_t prep_d, prep_q;
  stage_t mul_d, mul_q, len_d, len_q;
  logic signed [63:0] prod_d, prod_q;
  logic signed [AW-1:0] yr;
  logic signed [14:0] yaw_f;
  logic signed [AW-1:0] pr;
  logic signed [13:0] pitch_d, pitch_q;
  logic signed [14:0] yaw_q;
  logic done_q;

  assign busy_o = 1'b0;

  // input prep: sign fold into right half plane, zero-vector flag and negated z
  always_comb begin
    prep_d = '0;
    prep_d.valid = start_i;
    prep_d.zero = (dir_x_i == 16'sd0) && (dir_y_i == 16'sd0);
    prep_d.z = -(XW'(dir_z_i) <<< 14);
    if (dir_x_i < 0) begin
      prep_d.x = -(XW'(dir_x_i) <<< 14);
      prep_d.y = -(XW'(dir_y_i) <<< 14);
      prep_d.acc = (dir_y_i >= 0) ? AW'(180*65536) : -AW'(180*65536);
    end else begin
      prep_d.x = XW'(dir_x_i) <<< 14;
      prep_d.y = XW'(dir_y_i) <<< 14;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_q <= '0;
    end else begin
      prep_q <= prep_d;
    end
  end

  assign a_pipe[0] = prep_q;

  // yaw pass
  for (genvar i = 0; i < NS; i++) begin : g_yaw
    vtpy_rot u_rot (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(5'(i)),
      .in_i   (a_pipe[i]),
      .out_o  (a_pipe[i+1])
    );
  end

  // yaw rounding and fold, gain multiply
  always_comb begin
    yr = (a_pipe[NS].acc + AW'(512)) >>> 10;
    yaw_f = 15'(yr);
    if (yr > AW'(11520)) yaw_f = 15'(yr - AW'(23040));
    else if (yr <= -AW'(11520)) yaw_f = 15'(yr + AW'(23040));
    prod_d = 64'(a_pipe[NS].x) * 64'sd652032874;
    mul_d = a_pipe[NS];
    mul_d.yaw = yaw_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q <= '0;
    end else begin
      mul_q <= mul_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // gain removal and second pass setup
  always_comb begin
    len_d = mul_q;
    len_d.x = XW'(prod_q >>> 30);
    len_d.y = mul_q.z;
    len_d.acc = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  assign b_pipe[0] = len_q;

  // pitch pass
  for (genvar i = 0; i < NS; i++) begin : g_pitch
    vtpy_rot u_rot (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(5'(i)),
      .in_i   (b_pipe[i]),
      .out_o  (b_pipe[i+1])
    );
  end

  // pitch rounding, fold and zero-vector case
  always_comb begin
    pr = (b_pipe[NS].acc + AW'(512)) >>> 10;
    pitch_d = 14'(pr);
    if (pr > AW'(5696)) pitch_d = 14'(pr - AW'(11520));
    if (b_pipe[NS].zero) pitch_d = -14'sd5760;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= b_pipe[NS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pitch_q <= pitch_d;
    yaw_q <= b_pipe[NS].zero ? 15'sd0 : b_pipe[NS].yaw;
  end

  assign done_o = done_q;
  assign pitch_angle_o = pitch_q;
  assign yaw_angle_o = yaw_q;

  // checks
  a_idle_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !prep_q.valid |-> ##(2*NS+3) !done_o) else $error("spurious result");
  a_take_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prep_q.valid |-> ##(2*NS+3) done_o) else $error("lost result");
  a_pitch_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pitch_angle_o >= -14'sd5824)) else $error("pitch out of range");
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o) else $error("busy asserted");

endmodule

// ===== bench/vector_to_pitch_yaw_checker.sv =====
// vector_to_pitch_yaw_checker: watches the command and result transfers of the core,
// predicts pitch and yaw with its own cordic model and compares them in order
// depends on nothing but the port widths of vector_to_pitch_yaw_core

module vector_to_pitch_yaw_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_o,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] dir_z_i,
  input  logic               done_o,
  input  logic signed [13:0] pitch_angle_o,
  input  logic signed [14:0] yaw_angle_o,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count
);

  localparam int Steps = 16;

  typedef struct packed {
    logic signed [13:0] pitch;
    logic signed [14:0] yaw;
  } angles_t;

  angles_t expected_angles[$];

  longint atan_q16[24] = '{2949120, 1740967, 919879, 466945, 234379, 117266, 58666,
    29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  // vectoring rotations: drive y toward zero, accumulate the angle
  function automatic longint rotate_to_axis(inout longint x, inout longint y,
                                            input longint acc);
    longint xs, ys;
    for (int i = 0; i < Steps && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        acc += atan_q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        acc -= atan_q16[i];
      end
    end
    return acc;
  endfunction

  function automatic angles_t predict_angles(longint x, longint y, longint z);
    angles_t a;
    longint cx, cy, acc, yaw, pitch, len, pz;
    if (x == 0 && y == 0) begin
      yaw = 0;
      pitch = -5760;
    end else begin
      cx = x * 16384;
      cy = y * 16384;
      acc = 0;
      if (x < 0) begin
        acc = (y >= 0) ? 180 * 65536 : -180 * 65536;
        cx = -cx;
        cy = -cy;
      end
      acc = rotate_to_axis(cx, cy, acc);
      yaw = (acc + 512) >>> 10;
      if (yaw > 11520) yaw -= 23040;
      else if (yaw <= -11520) yaw += 23040;
      len = (cx * 64'sd652032874) >>> 30;
      pz = -z * 16384;
      acc = rotate_to_axis(len, pz, 0);
      pitch = (acc + 512) >>> 10;
      if (pitch > 5696) pitch -= 11520;
    end
    a.pitch = pitch[13:0];
    a.yaw = yaw[14:0];
    return a;
  endfunction

  assign pending_count = expected_angles.size();

  // predict on each command transfer, compare on each result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    angles_t e;
    if (!rst_ni) begin
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (start_i && !busy_o)
        expected_angles.push_back(predict_angles(dir_x_i, dir_y_i, dir_z_i));
      if (done_o) begin
        result_count <= result_count + 1;
        if (expected_angles.size() == 0) begin
          if (fail_count < 10) $display("unexpected result pitch=%0d yaw=%0d",
                                        pitch_angle_o, yaw_angle_o);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_angles.pop_front();
          if (e.pitch !== pitch_angle_o || e.yaw !== yaw_angle_o) begin
            if (fail_count < 10)
              $display("mismatch: pitch exp %0d got %0d, yaw exp %0d got %0d",
                       e.pitch, pitch_angle_o, e.yaw, yaw_angle_o);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== bench/vector_to_pitch_yaw_core_test.sv =====
// vector_to_pitch_yaw_core_test: drives direction vectors into the core and gives the verdict
// depends on vector_to_pitch_yaw_core and vector_to_pitch_yaw_checker

module vector_to_pitch_yaw_core_test;

  localparam int Latency = 2 * 16 + 5;
  localparam int IdleLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic signed [15:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic busy_o, done_o;
  logic signed [13:0] pitch_angle_o;
  logic signed [14:0] yaw_angle_o;
  int fail_count, pending_count, result_count;
  int vectors_sent = 0;
  int idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  vector_to_pitch_yaw_core dut (.*);
  vector_to_pitch_yaw_checker checker_i (.*);

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("watchdog expired");
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [15:0] pick_component();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // one command transfer, optionally preceded by idle cycles
  task automatic send_vector(input logic [15:0] x, y, z, input bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 20) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    dir_x_i <= x;
    dir_y_i <= y;
    dir_z_i <= z;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    vectors_sent++;
  endtask

  logic [15:0] corner[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff};

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: zero horizontal part, axis directions, extremes, both folds
    send_vector(16'h0000, 16'h0000, 16'h7fff, 1'b0);
    send_vector(16'h0000, 16'h0000, 16'h8000, 1'b0);
    send_vector(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_vector(16'h8000, 16'h0000, 16'h0000, 1'b0);
    send_vector(16'h8000, 16'hffff, 16'h0000, 1'b0);
    send_vector(16'h0000, 16'h7fff, 16'h0000, 1'b0);
    send_vector(16'h0000, 16'h8000, 16'h0000, 1'b0);
    send_vector(16'h0001, 16'h0000, 16'h8000, 1'b0);
    send_vector(16'h0001, 16'h0000, 16'h7fff, 1'b0);
    send_vector(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_vector(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    for (int i = 0; i < 12; i++)
      send_vector(corner[$urandom_range(0, 4)], corner[$urandom_range(0, 4)],
                  corner[$urandom_range(0, 4)], 1'b1);
    // random: idles mixed in, with a long back-to-back stretch in the middle
    for (int i = 0; i < 650; i++)
      send_vector(pick_component(), pick_component(), pick_component(),
                  !(i >= 100 && i < 250));
    start_i <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    $display("sent %0d vectors, checked %0d results incl. axis and zero-length cases",
             vectors_sent, result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
